// File: sv/block_float_row_quantizer_top_macros.svh
// assertion helpers used by the quantizer top
`ifndef BLOCK_FLOAT_ROW_QUANTIZER_TOP_MACROS_SVH
`define BLOCK_FLOAT_ROW_QUANTIZER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define BFQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define BFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/bfq_pkg.sv
package bfq_pkg;

	localparam int MAX_LANES = 8;
	localparam int LANE_W    = 32;
	localparam int CNT_W     = 4;
	localparam int BYTE_W    = 8;
	localparam int QMAX      = 127;
	localparam int QMAG_W    = 7;
	// candidate scale exponents (before the fraction offset) run K_LOW .. K_LOW+K_STEPS-1
	localparam int K_LOW     = -6;
	localparam int K_STEPS   = 32;
	localparam int KIDX_W    = 5;
	// magnitudes are pre-shifted so every candidate becomes a plain right shift
	localparam int PRE_SHIFT = -K_LOW;
	localparam int WIDE_W    = LANE_W + PRE_SHIFT + 2;
	localparam int EXP_W     = 8;
	localparam int EXP_MIN   = -128;
	localparam int EXP_MAX   = 127;

	typedef logic signed [LANE_W-1:0] lane_t;
	typedef logic [LANE_W-1:0] mag_t;
	typedef lane_t [MAX_LANES-1:0] lane_row_t;
	typedef mag_t [MAX_LANES-1:0] mag_row_t;
	typedef logic [MAX_LANES-1:0][BYTE_W-1:0] byte_row_t;

	typedef struct packed {
		logic [KIDX_W-1:0] k_idx;
		logic              all_zero;
	} scale_ctl_t;

	// largest magnitude that fits in QMAX steps of 2^(idx+K_LOW)
	function automatic mag_t fit_limit(input int idx);
		longint lim;
		int     t;
		t = idx + K_LOW;
		if (t >= 0) begin
			lim = longint'(QMAX) << t;
		end else begin
			lim = longint'(QMAX) >> (-t);
		end
		return mag_t'(lim);
	endfunction

endpackage

// File: sv/bfq_max.sv
module bfq_max
	import bfq_pkg::*;
(
	input  lane_row_t               lanes,
	output mag_row_t                mags,
	output logic [MAX_LANES-1:0]    negs,
	output mag_t                    max_mag
);

	mag_t lvl1 [MAX_LANES/2];
	mag_t lvl2 [MAX_LANES/4];

	// sign and magnitude per lane, 0x80000000 gives 2^31
	always_comb begin
		for (int i = 0; i < MAX_LANES; i++) begin
			negs[i] = lanes[i][LANE_W-1];
			mags[i] = negs[i] ? (mag_t'(~lanes[i]) + 1'b1) : mag_t'(lanes[i]);
		end
	end

	// three-level compare tree
	always_comb begin
		for (int i = 0; i < MAX_LANES/2; i++) begin
			lvl1[i] = (mags[2*i] > mags[2*i+1]) ? mags[2*i] : mags[2*i+1];
		end
		for (int i = 0; i < MAX_LANES/4; i++) begin
			lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
		end
		max_mag = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
	end

endmodule

// File: sv/bfq_exp.sv
module bfq_exp
	import bfq_pkg::*;
(
	input  mag_t       max_mag,
	output scale_ctl_t ctl
);

	logic [K_STEPS-1:0] fit;
	logic [KIDX_W-1:0]  idx;

	// thermometer of candidates that hold the row maximum
	always_comb begin
		for (int j = 0; j < K_STEPS; j++) begin
			fit[j] = (max_mag <= fit_limit(j));
		end
	end

	// smallest fitting candidate, top one always fits
	always_comb begin
		idx = KIDX_W'(K_STEPS - 1);
		for (int j = K_STEPS - 1; j >= 0; j--) begin
			if (fit[j]) begin
				idx = KIDX_W'(j);
			end
		end
	end

	assign ctl.k_idx    = idx;
	assign ctl.all_zero = (max_mag == '0);

endmodule

// File: sv/bfq_scale.sv
module bfq_scale
	import bfq_pkg::*;
(
	input  mag_t              mag,
	input  logic              neg,
	input  logic [KIDX_W-1:0] k_idx,
	output logic [BYTE_W-1:0] q_byte
);

	logic [WIDE_W-1:0] wide;
	logic [WIDE_W-1:0] half;
	logic [WIDE_W-1:0] sum;
	logic [WIDE_W-1:0] q_full;
	logic [QMAG_W-1:0] q;
	logic [BYTE_W-1:0] qb;

	always_comb begin
		wide   = WIDE_W'(mag) << PRE_SHIFT;
		// round half away from zero on the magnitude
		half   = (k_idx == '0) ? '0 : (WIDE_W'(1) << (k_idx - 1'b1));
		sum    = wide + half;
		q_full = sum >> k_idx;
		q      = (q_full > WIDE_W'(QMAX)) ? QMAG_W'(QMAX) : q_full[QMAG_W-1:0];
		qb     = {1'b0, q};
		q_byte = neg ? (BYTE_W'(0) - qb) : qb;
	end

endmodule

// File: sv/block_float_row_quantizer_top.sv
// Block floating-point row quantizer. Each request carries one row of eight signed
// Q(32-FRAC_BITS).FRAC_BITS lanes plus a count of leading valid lanes (counts above
// LANES saturate). The row maximum magnitude picks the smallest power-of-two
// exponent that fits it in 127 steps; every valid lane is scaled by it, rounded
// half away from zero and clamped to +/-127, and lanes past the count read zero.
// An all-zero row gives exponent 0. Four register stages (input, magnitude/max,
// exponent select, scaled output) accept one row every cycle while the output
// is not stalled; a row passes through them in that order. A stall on the output
// backs up through the stages, and in_stall rises only when all four stages hold
// a row and the output is stalled.
module block_float_row_quantizer_top
	import bfq_pkg::*;
#(
	parameter int LANES     = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [LANE_W-1:0] value_lane0,
	input  logic signed [LANE_W-1:0] value_lane1,
	input  logic signed [LANE_W-1:0] value_lane2,
	input  logic signed [LANE_W-1:0] value_lane3,
	input  logic signed [LANE_W-1:0] value_lane4,
	input  logic signed [LANE_W-1:0] value_lane5,
	input  logic signed [LANE_W-1:0] value_lane6,
	input  logic signed [LANE_W-1:0] value_lane7,
	input  logic [CNT_W-1:0]         valid_count,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [MAX_LANES*BYTE_W-1:0] packed_lanes,
	output logic signed [EXP_W-1:0]  shared_exponent
);

	localparam logic [CNT_W-1:0] LANES_C = CNT_W'(LANES);
	// exponent = candidate index + K_LOW - FRAC_BITS
	localparam int E_OFS = K_LOW - FRAC_BITS;

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	// stage payloads
	lane_row_t            lanes_s1;
	mag_row_t             mags_s2, mags_s3;
	logic [MAX_LANES-1:0] negs_s2, negs_s3;
	mag_t                 max_s2;
	scale_ctl_t           ctl_s3;
	byte_row_t            bytes_s4;
	logic [EXP_W-1:0]     exp_s4;

	// combinational results per stage
	lane_row_t            row_in;
	logic [CNT_W-1:0]     cnt_eff;
	mag_row_t             mags_c;
	logic [MAX_LANES-1:0] negs_c;
	mag_t                 max_c;
	scale_ctl_t           ctl_c;
	byte_row_t            bytes_c;
	logic [EXP_W-1:0]     exp_c;
	int                   e_full;

	// a stage may load when empty or when its row moves on
	assign rdy_s4   = !v_s4 || !out_stall;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	// count saturation and zeroing of lanes past the count
	always_comb begin
		cnt_eff   = (valid_count > LANES_C) ? LANES_C : valid_count;
		row_in[0] = value_lane0;
		row_in[1] = value_lane1;
		row_in[2] = value_lane2;
		row_in[3] = value_lane3;
		row_in[4] = value_lane4;
		row_in[5] = value_lane5;
		row_in[6] = value_lane6;
		row_in[7] = value_lane7;
		for (int i = 0; i < MAX_LANES; i++) begin
			if (!(CNT_W'(i) < cnt_eff)) begin
				row_in[i] = '0;
			end
		end
	end

	// magnitudes and row maximum
	bfq_max u_max (
		.lanes   (lanes_s1),
		.mags    (mags_c),
		.negs    (negs_c),
		.max_mag (max_c)
	);

	// exponent candidate select
	bfq_exp u_exp (
		.max_mag (max_s2),
		.ctl     (ctl_c)
	);

	// per-lane scale, round and clamp
	for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
		bfq_scale u_scale (
			.mag    (mags_s3[g]),
			.neg    (negs_s3[g]),
			.k_idx  (ctl_s3.k_idx),
			.q_byte (bytes_c[g])
		);
	end

	// shared exponent, clamped for totality, zero for an all-zero row
	always_comb begin
		e_full = int'(ctl_s3.k_idx) + E_OFS;
		if (e_full < EXP_MIN) begin
			e_full = EXP_MIN;
		end
		if (e_full > EXP_MAX) begin
			e_full = EXP_MAX;
		end
		exp_c = ctl_s3.all_zero ? '0 : EXP_W'(e_full);
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// stage payloads, no reset needed
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			lanes_s1 <= row_in;
		end
		if (rdy_s2 && v_s1) begin
			mags_s2 <= mags_c;
			negs_s2 <= negs_c;
			max_s2  <= max_c;
		end
		if (rdy_s3 && v_s2) begin
			mags_s3 <= mags_s2;
			negs_s3 <= negs_s2;
			ctl_s3  <= ctl_c;
		end
		if (rdy_s4 && v_s3) begin
			bytes_s4 <= bytes_c;
			exp_s4   <= exp_c;
		end
	end

	assign out_valid       = v_s4;
	assign packed_lanes    = bytes_s4;
	assign shared_exponent = exp_s4;

	`include "block_float_row_quantizer_top_macros.svh"

	// input only backs up when every stage is full and the output is held
	`BFQ_ASSERT_NOW(a_stall_full, clk, arst_n, in_stall, v_s1 && v_s2 && v_s3 && out_valid && out_stall, "in_stall without a full pipeline")
	// an empty row carries a zero exponent
	`BFQ_ASSERT_NOW(a_zero_exp, clk, arst_n, out_valid && (packed_lanes == '0), shared_exponent == '0, "nonzero exponent on an all-zero row")
	// a taken result with nothing behind it leaves the output empty
	`BFQ_ASSERT_NEXT(a_drain, clk, arst_n, out_valid && !out_stall && !v_s3, !out_valid, "result repeated after delivery")

	for (genvar g = 0; g < MAX_LANES; g++) begin : g_chk
		// the clamp never yields -128
		`BFQ_ASSERT_NOW(a_no_min, clk, arst_n, out_valid, packed_lanes[g*BYTE_W +: BYTE_W] != 8'h80, "lane byte at -128")
	end

endmodule

// File: tb/bfq_row_checker.sv
module bfq_row_checker
	import bfq_pkg::*;
#(
	parameter int LANES     = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  lane_row_t                   row,
	input  logic [CNT_W-1:0]            valid_count,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [MAX_LANES*BYTE_W-1:0] packed_lanes,
	input  logic signed [EXP_W-1:0]     shared_exponent,
	output int unsigned                 mismatches,
	output int unsigned                 rows_waiting,
	output int unsigned                 rows_checked
);

	typedef struct packed {
		logic [MAX_LANES*BYTE_W-1:0] q_lanes;
		logic signed [EXP_W-1:0]     expo;
	} quant_row_t;

	quant_row_t quant_rows_due[$];

	// block floating-point quantization of one row
	function automatic quant_row_t quantize_row(lane_row_t r, logic [CNT_W-1:0] cnt);
		quant_row_t res;
		int         n;
		int         i;
		int         t;
		int         k;
		int         e;
		int         sh;
		bit         found;
		longint     mag [MAX_LANES];
		longint     peak;
		longint     q;
		longint     lane_q;
		n = cnt;
		if (n > LANES) begin
			n = LANES;
		end
		peak = 0;
		for (i = 0; i < MAX_LANES; i++) begin
			mag[i] = (r[i] < 0) ? -longint'(r[i]) : longint'(r[i]);
			if (i < n && mag[i] > peak) begin
				peak = mag[i];
			end
		end
		// smallest step 2^k that holds the peak in QMAX steps
		k = K_LOW + K_STEPS - 1;
		found = 0;
		for (t = K_LOW; t <= K_LOW + K_STEPS - 1; t++) begin
			if (!found) begin
				if (t >= 0 ? (peak <= (longint'(QMAX) << t)) : ((peak << (-t)) <= QMAX)) begin
					k = t;
					found = 1;
				end
			end
		end
		e = (peak == 0) ? 0 : k - FRAC_BITS;
		if (e < EXP_MIN) begin
			e = EXP_MIN;
		end
		if (e > EXP_MAX) begin
			e = EXP_MAX;
		end
		sh = e + FRAC_BITS;
		res.q_lanes = '0;
		res.expo = EXP_W'(e);
		for (i = 0; i < n; i++) begin
			if (mag[i] == 0 || peak == 0) begin
				q = 0;
			end else if (sh > 0) begin
				q = (sh > 40) ? 0 : ((mag[i] + (longint'(1) << (sh - 1))) >>> sh);
			end else if (sh < 0) begin
				q = (-sh > 7) ? QMAX : (mag[i] << (-sh));
			end else begin
				q = mag[i];
			end
			if (q > QMAX) begin
				q = QMAX;
			end
			lane_q = (r[i] < 0) ? -q : q;
			res.q_lanes[BYTE_W*i +: BYTE_W] = lane_q[BYTE_W-1:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		quant_row_t want;
		if (!arst_n) begin
			quant_rows_due.delete();
			mismatches = 0;
			rows_checked = 0;
			rows_waiting = 0;
		end else begin
			// results first, so a result can never match a request of the same edge
			if (out_valid && !out_stall) begin
				if (quant_rows_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result with nothing due: lanes %h exp %0d",
							$realtime, packed_lanes, shared_exponent);
					end
				end else begin
					want = quant_rows_due.pop_front();
					rows_checked++;
					if (packed_lanes !== want.q_lanes) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: packed_lanes expected %h got %h",
								$realtime, want.q_lanes, packed_lanes);
						end
					end
					if (shared_exponent !== want.expo) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: shared_exponent expected %0d got %0d",
								$realtime, want.expo, shared_exponent);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				quant_rows_due.push_back(quantize_row(row, valid_count));
			end
			rows_waiting = quant_rows_due.size();
		end
	end

endmodule

// File: tb/tb_top.sv
module tb_top;
	import bfq_pkg::*;

	localparam int PERIOD      = 20;
	localparam int ROWS_PER_PH = 334;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	lane_row_t                   row = '0;
	logic [CNT_W-1:0]            valid_count = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [MAX_LANES*BYTE_W-1:0] packed_lanes;
	logic signed [EXP_W-1:0]     shared_exponent;

	// idle mix for both sides, in percent of cycles
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	// cycles of forced output stall still to go
	int unsigned hold_left = 0;
	int unsigned rows_sent = 0;
	int unsigned directed_rows = 0;
	int unsigned mismatches;
	int unsigned rows_waiting;
	int unsigned rows_checked;

	block_float_row_quantizer_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.value_lane0    (row[0]),
		.value_lane1    (row[1]),
		.value_lane2    (row[2]),
		.value_lane3    (row[3]),
		.value_lane4    (row[4]),
		.value_lane5    (row[5]),
		.value_lane6    (row[6]),
		.value_lane7    (row[7]),
		.valid_count    (valid_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.packed_lanes   (packed_lanes),
		.shared_exponent(shared_exponent)
	);

	// predicts each request's result and compares on the output side
	bfq_row_checker quant_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.row            (row),
		.valid_count    (valid_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.packed_lanes   (packed_lanes),
		.shared_exponent(shared_exponent),
		.mismatches     (mismatches),
		.rows_waiting   (rows_waiting),
		.rows_checked   (rows_checked)
	);

	initial begin
		clk = 1'b0;
		forever #(PERIOD/2) clk = ~clk;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#(PERIOD * 400000);
		$display("tb_top NOT OK");
		$finish;
	end

	// output side: random stall, or a long forced hold-off when one is pending
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// offer one request, idling first at random, and wait until it is taken
	// in_valid gets exactly one assignment per edge, so back-to-back rows stay high
	task automatic offer_row(input lane_row_t r, input logic [CNT_W-1:0] cnt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		row <= r;
		valid_count <= cnt;
		do @(posedge clk); while (in_stall);
		rows_sent++;
	endtask

	// lane values spread over all magnitudes, with the corner values mixed in
	function automatic lane_t random_lane();
		logic [LANE_W-1:0] v;
		case ($urandom_range(9))
			0: v = '0;
			1: v = 32'h7fff_ffff;
			2: v = 32'h8000_0000;
			3: v = $urandom_range(3);
			4, 5, 6: v = $urandom >> $urandom_range(31);
			default: v = $urandom;
		endcase
		if (v != 32'h8000_0000 && $urandom_range(1)) begin
			v = -v;
		end
		return lane_t'(v);
	endfunction

	// mostly legal counts, some empty rows and some counts past the lane limit
	function automatic logic [CNT_W-1:0] random_count();
		case ($urandom_range(19))
			0: return '0;
			1, 2: return CNT_W'($urandom_range(15, 9));
			default: return CNT_W'($urandom_range(8, 1));
		endcase
	endfunction

	// rows whose lanes mostly share one magnitude scale, so the rounding is exercised near each step
	function automatic lane_row_t random_row();
		lane_row_t r;
		int        i;
		int        sh;
		sh = $urandom_range(31);
		for (i = 0; i < MAX_LANES; i++) begin
			if ($urandom_range(3) == 0) begin
				r[i] = random_lane();
			end else begin
				r[i] = lane_t'(($urandom >> sh) ^ ($urandom_range(1) ? 32'hffff_ffff : 32'h0));
			end
		end
		return r;
	endfunction

	initial begin
		lane_row_t r;
		int        i;
		int        ph;
		int        n;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, back to back
		// all lanes zero: exponent 0
		r = '0;
		offer_row(r, CNT_W'(8));
		// count zero hides even the largest lanes
		for (i = 0; i < MAX_LANES; i++) r[i] = 32'h7fff_ffff;
		offer_row(r, CNT_W'(0));
		// largest positive row, then the most negative row
		offer_row(r, CNT_W'(8));
		for (i = 0; i < MAX_LANES; i++) r[i] = 32'h8000_0000;
		offer_row(r, CNT_W'(8));
		// both extremes interleaved
		for (i = 0; i < MAX_LANES; i++) r[i] = i[0] ? 32'h8000_0000 : 32'h7fff_ffff;
		offer_row(r, CNT_W'(8));
		// smallest nonzero magnitude: lowest exponent
		r = '0;
		r[0] = 1;
		offer_row(r, CNT_W'(1));
		r[0] = -1;
		r[1] = 1;
		offer_row(r, CNT_W'(2));
		// exact fit of 127 steps beside a smaller lane
		r = '0;
		r[0] = 127;
		r[1] = -64;
		offer_row(r, CNT_W'(2));
		// halves round away from zero on both signs
		r = '0;
		r[0] = 128;
		r[1] = 3;
		r[2] = -3;
		r[3] = 1;
		r[4] = -1;
		offer_row(r, CNT_W'(5));
		// one past an exact step boundary
		r = '0;
		r[0] = (127 << 10) + 1;
		r[1] = -(127 << 10);
		r[2] = 1 << 9;
		offer_row(r, CNT_W'(3));
		// one and minus one and a half in Q16.16
		r = '0;
		r[0] = 32'h0001_0000;
		r[1] = -32'sh0001_8000;
		offer_row(r, CNT_W'(2));
		// large lanes past the count take no part
		for (i = 0; i < MAX_LANES; i++) r[i] = (i < 3) ? 5 * (i + 1) : 32'h7fff_ffff;
		offer_row(r, CNT_W'(3));
		// counts past the lane limit saturate
		for (i = 0; i < MAX_LANES; i++) r[i] = (i - 4) * 1000;
		offer_row(r, CNT_W'(9));
		offer_row(r, CNT_W'(15));
		// every legal count once
		for (n = 1; n <= MAX_LANES; n++) begin
			for (i = 0; i < MAX_LANES; i++) r[i] = (i == n - 1) ? -32'sd77777 : 32'sd1234 * i;
			offer_row(r, CNT_W'(n));
		end
		directed_rows = rows_sent;

		// random rows under three idle mixes, the last with no idling at all
		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 52 : 0;
			recv_stall_pct = (ph == 0) ? 52 : (ph == 1) ? 30 : 0;
			for (n = 0; n < ROWS_PER_PH; n++) begin
				// long output hold-off while the input keeps offering, so the pipe fills
				if (ph == 2 && n == ROWS_PER_PH / 2) begin
					hold_left = 120;
				end
				offer_row(random_row(), random_count());
			end
		end
		in_valid <= 1'b0;

		// drain, then keep waiting so that anything stray can show up
		while (rows_waiting != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d rows (%0d directed) under three idle mixes and a long output hold-off",
			rows_sent, directed_rows);
		$display("compared %0d results, %0d mismatches", rows_checked, mismatches);
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/bfq_pkg.sv
sv/bfq_max.sv
sv/bfq_exp.sv
sv/bfq_scale.sv
sv/block_float_row_quantizer_top.sv
tb/bfq_row_checker.sv
tb/tb_top.sv
